FILE: hw/rtl/bdq_pkg.sv
package bdq_pkg;

  // Storage geometry of the ring.
  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Field widths of the transaction payloads.
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [VALUE_W-1:0] value;
  } bdq_cmd_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0]        count;
    logic                      empty_res;
  } bdq_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
  } bdq_ctl_t;

  // Wrap a ring position that is known to be below twice the capacity.
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] pos);
    logic [SUM_W-1:0] cap;
    cap = SUM_W'(CAPACITY);
    if (pos >= cap) begin
      ring_wrap = IDX_W'(pos - cap);
    end else begin
      ring_wrap = IDX_W'(pos);
    end
  endfunction

endpackage

FILE: hw/rtl/bdq_ctrl.sv
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output bdq_pkg::bdq_ctl_t   ctl
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);
  assign ctl.load = (state == ST_IDLE) && start;
  assign ctl.exec = (state == ST_EXEC);
  assign ctl.rd   = (state == ST_READ);

endmodule

FILE: hw/rtl/bdq_dpath.sv
module bdq_dpath (
  input  logic              clk,
  input  logic              rst,
  input  bdq_pkg::bdq_ctl_t ctl,
  input  bdq_pkg::bdq_cmd_t cmd,
  output bdq_pkg::bdq_res_t res
);

  logic [bdq_pkg::DATA_WIDTH-1:0] ring_store [bdq_pkg::CAPACITY];

  logic [bdq_pkg::OPCODE_W-1:0]   opcode;
  logic [bdq_pkg::DATA_WIDTH-1:0] value;
  logic [bdq_pkg::IDX_W-1:0]      front_index;
  logic [bdq_pkg::IDX_W-1:0]      front_index_next;
  logic [bdq_pkg::CNT_W-1:0]      item_count;
  logic [bdq_pkg::CNT_W-1:0]      item_count_next;
  logic                           ok;
  logic                           ok_next;
  logic [bdq_pkg::DATA_WIDTH-1:0] rd_front;
  logic [bdq_pkg::DATA_WIDTH-1:0] rd_back;

  logic                           full;
  logic                           queue_empty;
  logic                           wr_en;
  logic [bdq_pkg::IDX_W-1:0]      wr_addr;
  logic [bdq_pkg::IDX_W-1:0]      front_dec;
  logic [bdq_pkg::IDX_W-1:0]      front_inc;
  logic [bdq_pkg::IDX_W-1:0]      tail_pos;
  logic [bdq_pkg::IDX_W-1:0]      back_pos;

  assign full        = (item_count == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
  assign queue_empty = (item_count == '0);

  assign front_dec = (front_index == '0) ? bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)
                                         : front_index - 1'b1;
  assign front_inc = (front_index == bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)) ? '0
                                         : front_index + 1'b1;
  assign tail_pos  = bdq_pkg::ring_wrap(bdq_pkg::SUM_W'(front_index)
                                        + bdq_pkg::SUM_W'(item_count));
  // Only meaningful when the queue is not empty.
  assign back_pos  = bdq_pkg::ring_wrap(bdq_pkg::SUM_W'(front_index)
                                        + bdq_pkg::SUM_W'(item_count - 1'b1));

  always_comb begin
    front_index_next = front_index;
    item_count_next  = item_count;
    ok_next          = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = tail_pos;
    case (opcode)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          front_index_next = front_dec;
          item_count_next  = item_count + 1'b1;
          wr_en            = 1'b1;
          wr_addr          = front_dec;
          ok_next          = 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (!full) begin
          item_count_next = item_count + 1'b1;
          wr_en           = 1'b1;
          ok_next         = 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (!queue_empty) begin
          front_index_next = front_inc;
          item_count_next  = item_count - 1'b1;
          ok_next          = 1'b1;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (!queue_empty) begin
          item_count_next = item_count - 1'b1;
          ok_next         = 1'b1;
        end
      end
      bdq_pkg::OP_QUERY: ok_next = 1'b1;
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      item_count  <= '0;
    end else if (ctl.exec) begin
      front_index <= front_index_next;
      item_count  <= item_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opcode <= cmd.opcode;
      value  <= bdq_pkg::DATA_WIDTH'(cmd.value);
    end
    if (ctl.exec) begin
      ok <= ok_next;
    end
  end

  // Ring store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      ring_store[wr_addr] <= value;
    end
    if (ctl.rd) begin
      rd_front <= ring_store[front_index];
      rd_back  <= ring_store[back_pos];
    end
  end

  assign res.ok          = ok;
  assign res.front_value = queue_empty ? '1 : bdq_pkg::VALUE_W'(signed'(rd_front));
  assign res.back_value  = queue_empty ? '1 : bdq_pkg::VALUE_W'(signed'(rd_back));
  assign res.count       = bdq_pkg::COUNT_W'(item_count);
  assign res.empty_res   = queue_empty;

endmodule

FILE: hw/rtl/bounded_deque.sv
// Bounded double-ended queue held in a ring store with a front index and a count.
// A transaction is latched when start is taken in idle, steps through the update,
// read and done states and is strobed on done; busy stays high through done, so none
// is taken before the last is through. The ring store is written in update, read in read.
// Reset (rst, synchronous, active high) empties the queue and idles the controller.
// The receiver cannot stall: each result is valid for exactly the one cycle of done.
module bounded_deque (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bdq_pkg::bdq_cmd_t cmd,
  output logic              done,
  output bdq_pkg::bdq_res_t res
);

  // Command lines from the controller into the datapath.
  bdq_pkg::bdq_ctl_t ctl;

  // The controller steps each transaction through latch, update, read and
  // report phases.
  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // The datapath owns the ring store, the front index and the item count.
  // It applies the operation in the update phase, reads the front and back
  // entries in the read phase, and holds the result steady while done is high.
  // An empty queue reports -1 at both ends.
  bdq_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cmd (cmd),
    .res (res)
  );

endmodule
